### rtl/srac_pkg.sv
// Package for the stereo reverb unit: sizes, coefficient and layout tables,
// and the saturation helpers used by the datapath; the interfaces use the sizes.
// No dependencies.
`default_nettype none

package srac_pkg;

  localparam int DelayWords  = 16384;
  localparam int AddrBits    = $clog2(DelayWords);
  localparam int SampleBits  = 16;
  localparam int WordBits    = SampleBits + 8;
  localparam int PosBits     = 13;
  localparam int Stages      = 7;
  localparam int NumTaps     = 6;
  localparam int ProdBits    = 42;
  localparam int SumBits     = WordBits + 3;
  localparam int OutProdBits = SumBits + 16;

  localparam logic [1:0] RegMode  = 2'd0;
  localparam logic [1:0] RegDecay = 2'd1;
  localparam logic [1:0] RegWet   = 2'd2;

  localparam logic [PosBits-1:0] StageLen [0:2][0:6] = '{
    '{13'd705, 13'd994, 13'd729, 13'd78, 13'd2349, 13'd2839, 13'd3632},
    '{13'd961, 13'd1324, 13'd809, 13'd176, 13'd2619, 13'd3545, 13'd4519},
    '{13'd116, 13'd969, 13'd644, 13'd157, 13'd2259, 13'd2839, 13'd3539}};

  localparam logic [AddrBits-1:0] StageBase [0:2][0:6] = '{
    '{14'd0, 14'd705, 14'd1699, 14'd2428, 14'd2506, 14'd4855, 14'd7694},
    '{14'd0, 14'd961, 14'd2285, 14'd3094, 14'd3270, 14'd5889, 14'd9434},
    '{14'd0, 14'd116, 14'd1085, 14'd1729, 14'd1886, 14'd4145, 14'd6984}};

  // Tap order: first left tap (read before comb one is updated), right tap of
  // comb one, left of comb two, left of comb three, right of two, right of three.
  localparam logic [PosBits-1:0] TapBack [0:2][0:5] = '{
    '{13'd2348, 13'd1174, 13'd141, 13'd1960, 13'd1570, 13'd145},
    '{13'd2617, 13'd1300, 13'd1760, 13'd4518, 13'd3532, 13'd2274},
    '{13'd2258, 13'd1136, 13'd718, 13'd1769, 13'd2128, 13'd1}};

  localparam logic [2:0] TapStage [0:5] = '{3'd4, 3'd4, 3'd5, 3'd6, 3'd5, 3'd6};
  localparam logic       TapLeft  [0:5] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};

  localparam logic signed [15:0] LowpassQ [0:2] = '{16'sd22537, 16'sd23332, 16'sd30680};

  localparam logic signed [15:0] FeedbackQ [0:2][0:7] = '{
    '{-16'sd8192, -16'sd14746, -16'sd19661, -16'sd24576,
      -16'sd26214, -16'sd27853, -16'sd29491, -16'sd31130},
    '{-16'sd8192, -16'sd14746, -16'sd19661, -16'sd22938,
      -16'sd24576, -16'sd26214, -16'sd29491, -16'sd31130},
    '{-16'sd7373, -16'sd13107, -16'sd18022, -16'sd20316,
      -16'sd23593, -16'sd27197, -16'sd28180, -16'sd30638}};

  localparam logic signed [15:0] WetQ [0:2][0:7] = '{
    '{16'sd0, -16'sd1507, -16'sd2523, -16'sd3506,
      -16'sd4981, -16'sd6619, -16'sd8258, -16'sd9765},
    '{16'sd0, -16'sd1409, -16'sd2589, -16'sd3637,
      -16'sd4686, -16'sd6226, -16'sd7799, -16'sd9929},
    '{16'sd0, -16'sd1098, -16'sd2012, -16'sd2815,
      -16'sd3604, -16'sd4850, -16'sd6586, -16'sd7668}};

  function automatic logic signed [WordBits-1:0] sat_word(input logic signed [ProdBits-1:0] x);
    logic signed [ProdBits-1:0] hi;
    logic signed [ProdBits-1:0] lo;
    hi = ProdBits'((64'sd1 <<< (WordBits - 1)) - 64'sd1);
    lo = -hi - ProdBits'(1);
    if (x > hi) begin
      return hi[WordBits-1:0];
    end else if (x < lo) begin
      return lo[WordBits-1:0];
    end
    return x[WordBits-1:0];
  endfunction

  function automatic logic signed [SampleBits-1:0] sat_sample(
      input logic signed [OutProdBits-1:0] x);
    logic signed [OutProdBits-1:0] hi;
    logic signed [OutProdBits-1:0] lo;
    hi = OutProdBits'((64'sd1 <<< (SampleBits - 1)) - 64'sd1);
    lo = -hi - OutProdBits'(1);
    if (x > hi) begin
      return hi[SampleBits-1:0];
    end else if (x < lo) begin
      return lo[SampleBits-1:0];
    end
    return x[SampleBits-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/srac_if.sv
// Valid/ready channel interfaces for the stereo reverb unit: input pair,
// wet output pair and register writes. Depends on srac_pkg.
`default_nettype none

interface srac_smp_in_if import srac_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] left_sample;
  logic signed [SampleBits-1:0] right_sample;
  modport source (output valid, left_sample, right_sample, input ready);
  modport sink (input valid, left_sample, right_sample, output ready);
endinterface

interface srac_smp_out_if import srac_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] wet_left;
  logic signed [SampleBits-1:0] wet_right;
  modport source (output valid, wet_left, wet_right, input ready);
  modport sink (input valid, wet_left, wet_right, output ready);
endinterface

interface srac_cfg_if ();
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [2:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/stereo_reverb_allpass_comb_unit.sv
// Top level of the stereo reverb: sequencer, shared delay RAM and datapath.
// Depends on srac_pkg and the channel interfaces in srac_if.sv.
//
// Channel  Direction  Payload
// in_i     sink       left_sample, right_sample
// out_o    source     wet_left, wet_right
// cfg_i    sink       index, data (reverb_mode, decay_time_index, wet_level_index)
//
// Each pair runs through its comb, allpass, tap and output steps in turn, from
// acceptance to a loaded output register, and the unit returns to idle before the
// next pair is taken. The single-port delay RAM carries one read or write per cycle.
// After reset all 16384 RAM words are cleared, one word a cycle, before input is taken.
// A stalled output holds the unit in its final step; once the result is loaded,
// the next pair is taken while it waits.
// Register writes are taken at any time and must arrive while the unit is idle.
`default_nettype none

module stereo_reverb_allpass_comb_unit import srac_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  srac_smp_in_if.sink   in_i,
  srac_smp_out_if.source out_o,
  srac_cfg_if.sink      cfg_i
);

  typedef enum logic [12:0] {
    ST_CLEAR   = 13'b0000000000001,
    ST_IDLE    = 13'b0000000000010,
    ST_C_LAST  = 13'b0000000000100,
    ST_C_OLD   = 13'b0000000001000,
    ST_C_FB    = 13'b0000000010000,
    ST_C_LP    = 13'b0000000100000,
    ST_C_WR    = 13'b0000001000000,
    ST_AP_RD   = 13'b0000010000000,
    ST_AP_WR   = 13'b0000100000000,
    ST_TAP_RD  = 13'b0001000000000,
    ST_TAP_ACC = 13'b0010000000000,
    ST_OUT_MUL = 13'b0100000000000,
    ST_OUT_FIN = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;
  logic [2:0] stg_q, stg_d;
  logic [2:0] tap_k_q, tap_k_d;
  logic [PosBits-1:0] pos_q [0:Stages-1];
  logic [AddrBits-1:0] clr_q;
  logic [1:0] mode_q;
  logic [2:0] decay_q, wet_idx_q;
  logic signed [SampleBits:0] dry_q;
  logic signed [WordBits-1:0] link_q, last_q, rd_q;
  logic signed [ProdBits-1:0] prod_q;
  logic signed [SumBits-1:0] sl_q, sr_q;
  logic signed [OutProdBits-1:0] pl_q, pr_q;
  logic signed [SampleBits-1:0] wl_q, wr_q;
  logic out_valid_q;

  logic [WordBits-1:0] mem [0:DelayWords-1];
  logic mem_re, mem_we;
  logic [AddrBits-1:0] mem_addr;
  logic signed [WordBits-1:0] mem_wdata;

  logic [1:0] row;
  logic [2:0] cur_stage;
  logic [PosBits-1:0] cur_pos, cur_len, nxt_pos, tap_pos, back;
  logic [AddrBits-1:0] base;
  logic signed [ProdBits-1:0] rnd15, x_ext, diff, comb_new;
  logic signed [ProdBits-1:0] ap_half_b, ap_st, ap_half_st, ap_out;
  logic signed [WordBits-1:0] st_word;
  logic signed [SumBits-1:0] tap_term;
  logic signed [15:0] fb_sel;
  logic out_load;

  assign row       = (mode_q == 2'd3) ? 2'd0 : mode_q;
  assign cur_stage = (state_q == ST_TAP_RD) ? TapStage[tap_k_q] : stg_q;
  assign cur_pos   = pos_q[cur_stage];
  assign cur_len   = StageLen[row][cur_stage];
  assign base      = StageBase[row][cur_stage];
  assign nxt_pos   = (cur_pos == cur_len - PosBits'(1)) ? '0 : cur_pos + PosBits'(1);
  assign back      = TapBack[row][tap_k_q];
  assign tap_pos   = (cur_pos >= back) ? cur_pos - back : cur_pos + cur_len - back;

  // Q1.15 rounding of the held product, and the comb's low-pass update.
  assign rnd15    = (prod_q + ProdBits'(16384)) >>> 15;
  assign x_ext    = (stg_q == 3'd0) ? ProdBits'(dry_q) : ProdBits'(link_q);
  assign diff     = x_ext + rnd15 - ProdBits'(last_q);
  assign comb_new = ProdBits'(last_q) + rnd15;
  assign fb_sel   = (stg_q == 3'd0) ? 16'sd0 : FeedbackQ[row][decay_q];

  // Allpass gain one half: the Q1.15 product reduces to (v + 1) >>> 1.
  assign ap_half_b  = (ProdBits'(rd_q) + ProdBits'(1)) >>> 1;
  assign st_word    = sat_word(ProdBits'(link_q) - ap_half_b);
  assign ap_st      = ProdBits'(st_word);
  assign ap_half_st = (ap_st + ProdBits'(1)) >>> 1;
  assign ap_out     = ProdBits'(rd_q) + ap_half_st;

  assign tap_term = (TapStage[tap_k_q] == 3'd6)
                  ? (SumBits'(rd_q) <<< 1)
                  : (SumBits'(rd_q) <<< 1) + SumBits'(rd_q);

  assign out_load = (state_q == ST_OUT_FIN) && (!out_valid_q || out_o.ready);

  always_comb begin
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = base + AddrBits'(nxt_pos);
    mem_wdata = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_q;
      end
      ST_C_LAST: begin
        mem_re   = 1'b1;
        mem_addr = base + AddrBits'(cur_pos);
      end
      ST_C_OLD, ST_AP_RD: begin
        mem_re = 1'b1;
      end
      ST_C_WR: begin
        mem_we    = 1'b1;
        mem_wdata = sat_word(comb_new);
      end
      ST_AP_WR: begin
        mem_we    = 1'b1;
        mem_wdata = st_word;
      end
      ST_TAP_RD: begin
        mem_re   = 1'b1;
        mem_addr = base + AddrBits'(tap_pos);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_addr];
    end
  end

  always_comb begin
    state_d = state_q;
    stg_d   = stg_q;
    tap_k_d = tap_k_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == AddrBits'(DelayWords - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = ST_C_LAST;
          stg_d   = 3'd0;
          tap_k_d = 3'd0;
        end
      end
      ST_C_LAST:  state_d = ST_C_OLD;
      ST_C_OLD:   state_d = ST_C_FB;
      ST_C_FB:    state_d = ST_C_LP;
      ST_C_LP:    state_d = ST_C_WR;
      ST_C_WR: begin
        if (stg_q == 3'd0) begin
          stg_d   = 3'd1;
          state_d = ST_AP_RD;
        end else if (stg_q == 3'd6) begin
          state_d = ST_TAP_RD;
        end else begin
          stg_d   = stg_q + 3'd1;
          state_d = ST_C_LAST;
        end
      end
      ST_AP_RD:   state_d = ST_AP_WR;
      ST_AP_WR: begin
        if (stg_q == 3'd3) begin
          state_d = ST_TAP_RD;
        end else begin
          stg_d   = stg_q + 3'd1;
          state_d = ST_AP_RD;
        end
      end
      ST_TAP_RD:  state_d = ST_TAP_ACC;
      ST_TAP_ACC: begin
        tap_k_d = tap_k_q + 3'd1;
        if (tap_k_q == 3'd0) begin
          stg_d   = 3'd4;
          state_d = ST_C_LAST;
        end else if (tap_k_q == 3'(NumTaps - 1)) begin
          state_d = ST_OUT_MUL;
        end else begin
          state_d = ST_TAP_RD;
        end
      end
      ST_OUT_MUL: state_d = ST_OUT_FIN;
      ST_OUT_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      stg_q       <= '0;
      tap_k_q     <= '0;
      clr_q       <= '0;
      mode_q      <= '0;
      decay_q     <= '0;
      wet_idx_q   <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < Stages; i++) begin
        pos_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      stg_q   <= stg_d;
      tap_k_q <= tap_k_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + AddrBits'(1);
      end
      if (state_q == ST_C_WR || state_q == ST_AP_WR) begin
        pos_q[stg_q] <= nxt_pos;
      end
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          RegMode: begin
            mode_q <= cfg_i.data[1:0];
            for (int i = 0; i < Stages; i++) begin
              pos_q[i] <= '0;
            end
          end
          RegDecay: decay_q   <= cfg_i.data;
          RegWet:   wet_idx_q <= cfg_i.data;
          default: begin
          end
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_i.valid) begin
      dry_q <= (SampleBits + 1)'(in_i.left_sample) + (SampleBits + 1)'(in_i.right_sample);
      sl_q  <= '0;
      sr_q  <= '0;
    end
    unique case (state_q)
      ST_C_OLD: last_q <= rd_q;
      ST_C_FB: begin
        prod_q <= ProdBits'(rd_q) * ProdBits'(fb_sel);
        if (stg_q == 3'd0) begin
          link_q <= rd_q;
        end
      end
      ST_C_LP:  prod_q <= diff * ProdBits'(LowpassQ[row]);
      ST_AP_WR: link_q <= sat_word(ap_out);
      ST_TAP_ACC: begin
        if (TapLeft[tap_k_q]) begin
          sl_q <= sl_q + tap_term;
        end else begin
          sr_q <= sr_q + tap_term;
        end
      end
      ST_OUT_MUL: begin
        pl_q <= OutProdBits'(sl_q) * OutProdBits'(WetQ[row][wet_idx_q]);
        pr_q <= OutProdBits'(sr_q) * OutProdBits'(WetQ[row][wet_idx_q]);
      end
      ST_OUT_FIN: begin
        if (out_load) begin
          wl_q <= sat_sample((pl_q + OutProdBits'(32768)) >>> 16);
          wr_q <= sat_sample((pr_q + OutProdBits'(32768)) >>> 16);
        end
      end
      default: begin
      end
    endcase
  end

  assign in_i.ready      = (state_q == ST_IDLE);
  assign cfg_i.ready     = 1'b1;
  assign out_o.valid     = out_valid_q;
  assign out_o.wet_left  = wl_q;
  assign out_o.wet_right = wr_q;

`ifndef SYNTHESIS
  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_CLEAR || state_q == ST_C_WR || state_q == ST_AP_WR))
    else $error("delay RAM written outside a write step");

  a_no_read_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("delay RAM read and written in one cycle");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_o.valid)
    else $error("finished transaction not presented");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_CLEAR) |-> (cur_pos < cur_len))
    else $error("ring position beyond its stage length");
`endif

endmodule

`default_nettype wire
